@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the word search RTL.
// Needs nothing else; pulled in by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GWS_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gws_pkg.sv @@
// Shared types, constants and helper functions of the word search block.
// No dependencies.
package gws_pkg;

    localparam int GRID_MAX_DEF = 64;
    localparam int WORD_MAX_DEF = 64;

    localparam int CHAR_W   = 8;
    localparam int OP_W     = 2;
    localparam int ROW_W    = 6;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;
    localparam int GS_W     = 7;
    localparam int COUNT_W  = 13;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [GS_W-1:0]    GS_RESET  = 7'd64;
    localparam logic [0:0]         REG_GRID_SIZE = 1'b0;

    localparam logic [OP_W-1:0] OP_LOAD_GRID = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_WORD = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH    = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_MARK = 2'd3;

    localparam logic KIND_COUNTS = 1'b0;
    localparam logic KIND_MARK   = 1'b1;

    localparam logic [2:0] DIR_N  = 3'd0;
    localparam logic [2:0] DIR_S  = 3'd1;
    localparam logic [2:0] DIR_E  = 3'd2;
    localparam logic [2:0] DIR_W  = 3'd3;
    localparam logic [2:0] DIR_NE = 3'd4;
    localparam logic [2:0] DIR_SE = 3'd5;
    localparam logic [2:0] DIR_SW = 3'd6;
    localparam logic [2:0] DIR_NW = 3'd7;

    typedef struct packed {
        logic grid_we;
        logic word_we;
        logic mark_we;
        logic mark_wval;
    } mem_ctl_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic signed [1:0] dir_row(input logic [2:0] d);
        case (d)
            DIR_N, DIR_NE, DIR_NW: return -2'sd1;
            DIR_S, DIR_SE, DIR_SW: return 2'sd1;
            default:               return 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] dir_col(input logic [2:0] d);
        case (d)
            DIR_E, DIR_NE, DIR_SE: return 2'sd1;
            DIR_W, DIR_SW, DIR_NW: return -2'sd1;
            default:               return 2'sd0;
        endcase
    endfunction

endpackage

@@ hw/rtl/gws_in_if.sv @@
// Input item channel: valid/ready handshake plus the command payload.
// Depends on gws_pkg.
interface gws_in_if
    import gws_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  column;
    logic [CHAR_W-1:0] character;
    logic [POS_W-1:0]  word_position;
    logic [LEN_W-1:0]  word_length;

    modport source (
        output valid, operation, row, column, character, word_position, word_length,
        input  ready
    );

    modport sink (
        input  valid, operation, row, column, character, word_position, word_length,
        output ready
    );
endinterface

@@ hw/rtl/gws_out_if.sv @@
// Result item channel: valid/ready handshake plus counts and marker payload.
// Depends on gws_pkg.
interface gws_out_if
    import gws_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [COUNT_W-1:0] count_north;
    logic [COUNT_W-1:0] count_south;
    logic [COUNT_W-1:0] count_east;
    logic [COUNT_W-1:0] count_west;
    logic [COUNT_W-1:0] count_northeast;
    logic [COUNT_W-1:0] count_southeast;
    logic [COUNT_W-1:0] count_southwest;
    logic [COUNT_W-1:0] count_northwest;
    logic               marked;

    modport source (
        output valid, result_kind, count_north, count_south, count_east, count_west,
               count_northeast, count_southeast, count_southwest, count_northwest, marked,
        input  ready
    );

    modport sink (
        input  valid, result_kind, count_north, count_south, count_east, count_west,
               count_northeast, count_southeast, count_southwest, count_northwest, marked,
        output ready
    );
endinterface

@@ hw/rtl/gws_apb.sv @@
// APB register slave holding the grid_size configuration register.
// Depends on gws_pkg.
module gws_apb
    import gws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [GS_W-1:0]    grid_size
);

    logic [GS_W-1:0] grid_size_reg;
    logic [GS_W-1:0] grid_size_next;
    logic            hit;

    assign pready = 1'b1;
    assign hit    = (paddr[PADDR_W-1:2] == REG_GRID_SIZE);

    always_comb
    begin
        grid_size_next = grid_size_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            grid_size_next = pwdata[GS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GS_RESET;
        end
        else
        begin
            grid_size_reg <= grid_size_next;
        end
    end

    assign prdata    = hit ? DATA_W'(grid_size_reg) : '0;
    assign grid_size = grid_size_reg;

endmodule

@@ hw/rtl/gws_mem.sv @@
// Grid, word and hit-marker memories, one port each, registered read data.
// Depends on gws_pkg.
module gws_mem
    import gws_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF,
    parameter int WORD_MAX = WORD_MAX_DEF,
    localparam int RAW = addr_w(GRID_MAX),
    localparam int CAW = 2 * RAW,
    localparam int WAW = addr_w(WORD_MAX)
)(
    input  logic              clk,
    input  mem_ctl_t          mem_ctl,
    input  logic [CAW-1:0]    grid_addr,
    input  logic [WAW-1:0]    word_addr,
    input  logic [CAW-1:0]    mark_addr,
    input  logic [CHAR_W-1:0] wchar,
    output logic [CHAR_W-1:0] grid_rdata,
    output logic [CHAR_W-1:0] word_rdata,
    output logic              mark_rdata
);

    localparam int CELL_N = 1 << CAW;
    localparam int WORD_N = 1 << WAW;

    logic [CHAR_W-1:0] grid_mem [CELL_N];
    logic [CHAR_W-1:0] word_mem [WORD_N];
    logic              mark_mem [CELL_N];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.grid_we)
        begin
            grid_mem[grid_addr] <= wchar;
        end
        grid_rdata <= grid_mem[grid_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.word_we)
        begin
            word_mem[word_addr] <= wchar;
        end
        word_rdata <= word_mem[word_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.mark_we)
        begin
            mark_mem[mark_addr] <= mem_ctl.mark_wval;
        end
        mark_rdata <= mark_mem[mark_addr];
    end

endmodule

@@ hw/rtl/gws_seq.sv @@
// Search sequencer: walks start cells, directions and word characters through
// one shared character compare. Depends on gws_pkg, assert_macros.svh.
`include "assert_macros.svh"

module gws_seq
    import gws_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF,
    parameter int WORD_MAX = WORD_MAX_DEF,
    localparam int RAW = addr_w(GRID_MAX),
    localparam int CAW = 2 * RAW,
    localparam int WAW = addr_w(WORD_MAX)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GS_W-1:0]   grid_size,
    gws_in_if.sink            in_ch,
    gws_out_if.source         out_ch,
    output mem_ctl_t          mem_ctl,
    output logic [CAW-1:0]    grid_addr,
    output logic [WAW-1:0]    word_addr,
    output logic [CAW-1:0]    mark_addr,
    input  logic [CHAR_W-1:0] grid_rdata,
    input  logic [CHAR_W-1:0] word_rdata,
    input  logic              mark_rdata
);

    localparam int PW  = $clog2(GRID_MAX + 1) + 1;
    localparam int NW  = PW - 1;
    localparam int LW  = $clog2(WORD_MAX + 1);
    localparam int AXW = (NW > ROW_W) ? NW : ROW_W;
    localparam int PXW = (LW > POS_W) ? LW : POS_W;
    localparam int GXW = (NW > GS_W) ? NW : GS_W;
    localparam int LXW = (LW > LEN_W) ? LW : LEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_MARK = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_MRD  = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [RAW-1:0]          r_reg, r_next;
    logic [RAW-1:0]          c_reg, c_next;
    logic [2:0]              d_reg, d_next;
    logic [LW-1:0]           i_reg, i_next;
    logic signed [PW-1:0]    pr_reg, pr_next;
    logic signed [PW-1:0]    pc_reg, pc_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [LW-1:0]           len_reg, len_next;
    logic [CAW-1:0]          clr_reg, clr_next;
    logic [COUNT_W-1:0]      cnt_reg [8];
    logic [COUNT_W-1:0]      cnt_next [8];
    logic                    live_reg, live_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    kind_reg, kind_next;
    logic                    marked_reg, marked_next;
    logic                    store_ok_reg, store_ok_next;

    logic                    accept;
    logic [AXW-1:0]          row_x, col_x;
    logic [PXW-1:0]          pos_x;
    logic                    in_store, pos_ok;
    logic [CAW-1:0]          in_addr, pos_addr;
    logic [GXW-1:0]          gs_x;
    logic [LXW-1:0]          wl_x;
    logic [NW-1:0]           n_sat;
    logic [LW-1:0]           len_sat;
    logic                    word_done, pos_in_grid, chars_eq;
    logic signed [PW-1:0]    dr_x, dc_x;
    logic [RAW-1:0]          n_m1;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;

    assign row_x    = AXW'(in_ch.row);
    assign col_x    = AXW'(in_ch.column);
    assign pos_x    = PXW'(in_ch.word_position);
    assign in_store = (row_x < AXW'(GRID_MAX)) && (col_x < AXW'(GRID_MAX));
    assign pos_ok   = pos_x < PXW'(WORD_MAX);
    assign in_addr  = {row_x[RAW-1:0], col_x[RAW-1:0]};
    assign pos_addr = {pr_reg[RAW-1:0], pc_reg[RAW-1:0]};

    assign gs_x    = GXW'(grid_size);
    assign wl_x    = LXW'(in_ch.word_length);
    assign n_sat   = (gs_x > GXW'(GRID_MAX)) ? NW'(GRID_MAX) : NW'(gs_x);
    assign len_sat = (wl_x > LXW'(WORD_MAX)) ? LW'(WORD_MAX) : LW'(wl_x);

    assign word_done   = (i_reg == len_reg);
    assign pos_in_grid = !pr_reg[PW-1] && (pr_reg[NW-1:0] < n_reg)
                      && !pc_reg[PW-1] && (pc_reg[NW-1:0] < n_reg);
    assign chars_eq    = (grid_rdata == word_rdata);
    assign dr_x        = PW'(dir_row(d_reg));
    assign dc_x        = PW'(dir_col(d_reg));
    assign n_m1        = RAW'(n_reg - 1'b1);

    assign grid_addr = (state_reg == S_IDLE) ? in_addr : pos_addr;
    assign word_addr = (state_reg == S_IDLE) ? pos_x[WAW-1:0] : i_reg[WAW-1:0];
    assign mark_addr = (state_reg == S_IDLE) ? in_addr
                     : ((state_reg == S_CLR) ? clr_reg : pos_addr);

    assign mem_ctl.grid_we   = accept && (in_ch.operation == OP_LOAD_GRID) && in_store;
    assign mem_ctl.word_we   = accept && (in_ch.operation == OP_LOAD_WORD) && pos_ok;
    assign mem_ctl.mark_we   = (state_reg == S_CLR) || ((state_reg == S_MARK) && !word_done);
    assign mem_ctl.mark_wval = (state_reg == S_MARK);

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        i_next         = i_reg;
        pr_next        = pr_reg;
        pc_next        = pc_reg;
        n_next         = n_reg;
        len_next       = len_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        live_next      = live_reg;
        kind_next      = kind_reg;
        marked_next    = marked_reg;
        store_ok_next  = store_ok_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_ch.operation == OP_SEARCH))
                begin
                    n_next   = n_sat;
                    len_next = len_sat;
                    clr_next = '0;
                    for (int k = 0; k < 8; k++)
                    begin
                        cnt_next[k] = '0;
                    end
                    state_next = S_CLR;
                end
                else if (accept && (in_ch.operation == OP_READ_MARK))
                begin
                    store_ok_next = in_store;
                    state_next    = S_MRD;
                end
            end
            S_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    live_next = 1'b1;
                    r_next    = '0;
                    c_next    = '0;
                    d_next    = DIR_N;
                    i_next    = '0;
                    pr_next   = '0;
                    pc_next   = '0;
                    state_next = (n_reg == '0) ? S_OUT : S_CMP;
                end
            end
            S_CMP:
            begin
                if (word_done)
                begin
                    if (cnt_reg[d_reg] != COUNT_MAX)
                    begin
                        cnt_next[d_reg] = cnt_reg[d_reg] + 1'b1;
                    end
                    i_next     = '0;
                    pr_next    = $signed(PW'(r_reg));
                    pc_next    = $signed(PW'(c_reg));
                    state_next = S_MARK;
                end
                else if (!pos_in_grid)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (chars_eq)
                begin
                    i_next     = i_reg + 1'b1;
                    pr_next    = pr_reg + dr_x;
                    pc_next    = pc_reg + dc_x;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_MARK:
            begin
                if (word_done)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    pr_next = pr_reg + dr_x;
                    pc_next = pc_reg + dc_x;
                end
            end
            S_NEXT:
            begin
                state_next = S_CMP;
                if (d_reg != DIR_NW)
                begin
                    d_next = d_reg + 1'b1;
                end
                else
                begin
                    d_next = DIR_N;
                    if (c_reg != n_m1)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = '0;
                        if (r_reg != n_m1)
                        begin
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
                i_next  = '0;
                pr_next = $signed(PW'(r_next));
                pc_next = $signed(PW'(c_next));
            end
            S_OUT:
            begin
                kind_next      = KIND_COUNTS;
                marked_next    = 1'b0;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_MRD:
            begin
                kind_next      = KIND_MARK;
                marked_next    = store_ok_reg && (!live_reg || mark_rdata);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= DIR_N;
            i_reg         <= '0;
            pr_reg        <= '0;
            pc_reg        <= '0;
            n_reg         <= '0;
            len_reg       <= '0;
            clr_reg       <= '0;
            live_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 8; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            i_reg         <= i_next;
            pr_reg        <= pr_next;
            pc_reg        <= pc_next;
            n_reg         <= n_next;
            len_reg       <= len_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        marked_reg   <= marked_next;
        store_ok_reg <= store_ok_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.result_kind     = kind_reg;
    assign out_ch.marked          = marked_reg;
    assign out_ch.count_north     = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_N];
    assign out_ch.count_south     = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_S];
    assign out_ch.count_east      = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_E];
    assign out_ch.count_west      = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_W];
    assign out_ch.count_northeast = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_NE];
    assign out_ch.count_southeast = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_SE];
    assign out_ch.count_southwest = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_SW];
    assign out_ch.count_northwest = (kind_reg == KIND_MARK) ? '0 : cnt_reg[DIR_NW];

    `GWS_ASSERT(a_mark_in_grid, clk, rst_n, mem_ctl.mark_we && (state_reg == S_MARK), pos_in_grid, "mark write outside grid")
    `GWS_ASSERT(a_chk_in_grid, clk, rst_n, state_reg == S_CHK, pos_in_grid, "grid read outside grid")
    `GWS_ASSERT(a_idx_bound, clk, rst_n, (state_reg == S_CMP) || (state_reg == S_CHK) || (state_reg == S_MARK), i_reg <= len_reg, "word index past length")
    `GWS_ASSERT(a_result_src, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_OUT) || $past(state_reg == S_MRD), "result without source")
    `GWS_ASSERT_NEXT(a_search_clears, clk, rst_n, accept && (in_ch.operation == OP_SEARCH), (state_reg == S_CLR) && (clr_reg == '0), "search did not start marker sweep")

endmodule

@@ hw/rtl/grid_word_search_eight_dir_core.sv @@
// Top level of the eight-direction word search block.
// Depends on gws_pkg, gws_in_if, gws_out_if, gws_apb, gws_mem, gws_seq.
//
//  port     | dir | handshake            | carries
//  ---------+-----+----------------------+-----------------------------------
//  in_ch    | in  | valid/ready          | operation, row, column, character,
//           |     |                      | word_position, word_length
//  out_ch   | out | valid/ready          | result_kind, eight counts, marked
//  apb      | in  | psel/penable, pready | grid_size at byte address 0
//
// Grid and word loads are written on acceptance; a marker read passes through S_MRD
// and delivers its item from the registered output. A search first clears the whole
// marker memory (GRID_MAX rounded up to a power of two, squared, cells), then per start
// cell and direction compares word characters, marks each matched cell on a match and
// advances; the single grid/word read port and the shared compare keep this walk serial.
// in_ch.ready is low while an item is in progress or a result waits to be taken.
// After reset every marker reads as set until the first search; counts read zero.
module grid_word_search_eight_dir_core
    import gws_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF,
    parameter int WORD_MAX = WORD_MAX_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    gws_in_if.sink             in_ch,
    gws_out_if.source          out_ch
);

    localparam int RAW = addr_w(GRID_MAX);
    localparam int CAW = 2 * RAW;
    localparam int WAW = addr_w(WORD_MAX);

    logic [GS_W-1:0]   grid_size;
    mem_ctl_t          mem_ctl;
    logic [CAW-1:0]    grid_addr;
    logic [WAW-1:0]    word_addr;
    logic [CAW-1:0]    mark_addr;
    logic [CHAR_W-1:0] grid_rdata;
    logic [CHAR_W-1:0] word_rdata;
    logic              mark_rdata;

    gws_apb u_apb (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .grid_size (grid_size)
    );

    gws_mem #(
        .GRID_MAX (GRID_MAX),
        .WORD_MAX (WORD_MAX)
    ) u_mem (
        .clk        (clk),
        .mem_ctl    (mem_ctl),
        .grid_addr  (grid_addr),
        .word_addr  (word_addr),
        .mark_addr  (mark_addr),
        .wchar      (in_ch.character),
        .grid_rdata (grid_rdata),
        .word_rdata (word_rdata),
        .mark_rdata (mark_rdata)
    );

    gws_seq #(
        .GRID_MAX (GRID_MAX),
        .WORD_MAX (WORD_MAX)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid_size  (grid_size),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mem_ctl    (mem_ctl),
        .grid_addr  (grid_addr),
        .word_addr  (word_addr),
        .mark_addr  (mark_addr),
        .grid_rdata (grid_rdata),
        .word_rdata (word_rdata),
        .mark_rdata (mark_rdata)
    );

endmodule

@@ verif/grid_word_search_eight_dir_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking test of grid_word_search_eight_dir_core: loads, searches and marker reads.
// Random gaps and stalls on both channels; a scoreboard predicts counts and marks per item.
// Depends on gws_pkg, gws_in_if, gws_out_if and the core RTL.
module grid_word_search_eight_dir_core_test;
    import gws_pkg::*;

    localparam int GMAX          = GRID_MAX_DEF;
    localparam int WMAX          = WORD_MAX_DEF;
    localparam int CLK_HALF      = 4;
    localparam int RANDOM_ITEMS  = 470;
    localparam int STALL_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int GS_TOP        = (1 << GS_W) - 1;

    localparam logic [PADDR_W-1:0] ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE     = {1'b1, 2'b00};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
    } command_t;

    typedef struct packed {
        logic                    kind;
        logic [7:0][COUNT_W-1:0] counts;
        logic                    marked;
    } result_t;

    class search_scoreboard;
        logic [CHAR_W-1:0]  grid [GMAX*GMAX];
        logic [CHAR_W-1:0]  word [WMAX];
        bit                 marks [GMAX*GMAX];
        logic [COUNT_W-1:0] hits [8];
        int                 step_row [8];
        int                 step_col [8];
        string              count_names [8];
        int unsigned        grid_size;
        result_t            pending_results [$];
        int                 errors;

        function new();
            foreach (grid[i])
            begin
                grid[i]  = '0;
                marks[i] = 1'b1;
            end
            foreach (word[i])
                word[i] = '0;
            foreach (hits[i])
                hits[i] = '0;
            step_row    = '{-1, 1, 0, 0, -1, 1, 1, -1};
            step_col    = '{0, 0, 1, -1, 1, 1, -1, -1};
            count_names = '{"count_north", "count_south", "count_east", "count_west",
                            "count_northeast", "count_southeast", "count_southwest",
                            "count_northwest"};
            grid_size   = 64;
            errors      = 0;
        endfunction

        function void write_register(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] value);
            if (addr == ADDR_GRID_SIZE)
                grid_size = value[GS_W-1:0];
        endfunction

        function bit word_fits(int r0, int c0, int d, int n, int len);
            int r;
            int c;
            int i;
            for (i = 0; i < len; i++)
            begin
                r = r0 + i * step_row[d];
                c = c0 + i * step_col[d];
                if (r < 0 || r >= n || c < 0 || c >= n)
                    return 1'b0;
                if (grid[r * GMAX + c] != word[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void find_words(int len);
            int n;
            int r;
            int c;
            int d;
            int i;
            n = (grid_size > GMAX) ? GMAX : int'(grid_size);
            if (len > WMAX)
                len = WMAX;
            foreach (marks[k])
                marks[k] = 1'b0;
            foreach (hits[k])
                hits[k] = '0;
            for (r = 0; r < n; r++)
                for (c = 0; c < n; c++)
                    for (d = 0; d < 8; d++)
                    begin
                        if (!word_fits(r, c, d, n, len))
                            continue;
                        if (hits[d] != COUNT_MAX)
                            hits[d]++;
                        for (i = 0; i < len; i++)
                            marks[(r + i * step_row[d]) * GMAX + c + i * step_col[d]] = 1'b1;
                    end
        endfunction

        function void accept_command(command_t cmd);
            result_t res;
            int      spot;
            int      d;
            spot = int'(cmd.row) * GMAX + int'(cmd.col);
            res  = '0;
            case (cmd.op)
                OP_LOAD_GRID: grid[spot] = cmd.ch;
                OP_LOAD_WORD: word[cmd.pos] = cmd.ch;
                OP_SEARCH:
                begin
                    find_words(int'(cmd.len));
                    res.kind = KIND_COUNTS;
                    for (d = 0; d < 8; d++)
                        res.counts[d] = hits[d];
                    pending_results.push_back(res);
                end
                OP_READ_MARK:
                begin
                    res.kind   = KIND_MARK;
                    res.marked = marks[spot];
                    pending_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            int      d;
            if (pending_results.size() == 0)
            begin
                $error("result_kind: expected no item, got %0d", got.kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("result_kind", COUNT_W'(want.kind), COUNT_W'(got.kind));
            for (d = 0; d < 8; d++)
                compare(count_names[d], want.counts[d], got.counts[d]);
            compare("marked", COUNT_W'(want.marked), COUNT_W'(got.marked));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    gws_in_if  in_ch ();
    gws_out_if out_ch ();

    search_scoreboard  board;
    bit                tx_steady = 1'b0;
    bit                rx_steady = 1'b0;
    int                items_sent = 0;
    int                quiet_cycles = 0;
    logic [CHAR_W-1:0] letter_a;
    logic [CHAR_W-1:0] letter_b;

    grid_word_search_eight_dir_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic command_t random_command();
        command_t cmd;
        cmd.op  = OP_W'($urandom);
        cmd.row = ROW_W'($urandom);
        cmd.col = ROW_W'($urandom);
        cmd.ch  = CHAR_W'($urandom);
        cmd.pos = POS_W'($urandom);
        cmd.len = LEN_W'($urandom);
        return cmd;
    endfunction

    // Long words only on tiny grids so a search stays short.
    function automatic int cheap_length(int n);
        if (n <= 4 && $urandom_range(0, 7) == 0)
            return $urandom_range(5, GS_TOP);
        return $urandom_range(0, 5);
    endfunction

    function automatic int region_coord(int n);
        if (n > 0 && $urandom_range(0, 7) != 0)
            return $urandom_range(0, (n > GMAX ? GMAX : n) - 1);
        return $urandom_range(0, GMAX - 1);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        return ($urandom_range(0, 1) == 0) ? letter_a : letter_b;
    endfunction

    task automatic send_command(input command_t cmd);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= cmd.op;
        in_ch.row           <= cmd.row;
        in_ch.column        <= cmd.col;
        in_ch.character     <= cmd.ch;
        in_ch.word_position <= cmd.pos;
        in_ch.word_length   <= cmd.len;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        board.accept_command(cmd);
        items_sent++;
    endtask

    task automatic load_cell(input int r, input int c, input logic [CHAR_W-1:0] ch);
        command_t cmd;
        cmd     = random_command();
        cmd.op  = OP_LOAD_GRID;
        cmd.row = ROW_W'(r);
        cmd.col = ROW_W'(c);
        cmd.ch  = ch;
        send_command(cmd);
    endtask

    task automatic load_letter(input int p, input logic [CHAR_W-1:0] ch);
        command_t cmd;
        cmd     = random_command();
        cmd.op  = OP_LOAD_WORD;
        cmd.pos = POS_W'(p);
        cmd.ch  = ch;
        send_command(cmd);
    endtask

    task automatic search(input int len);
        command_t cmd;
        cmd     = random_command();
        cmd.op  = OP_SEARCH;
        cmd.len = LEN_W'(len);
        send_command(cmd);
    endtask

    task automatic read_mark(input int r, input int c);
        command_t cmd;
        cmd     = random_command();
        cmd.op  = OP_READ_MARK;
        cmd.row = ROW_W'(r);
        cmd.col = ROW_W'(c);
        send_command(cmd);
    endtask

    // Holds the sender until every result is back and trailing loads are done.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_register(addr, value);
    endtask

    task automatic set_grid_size(input int n);
        logic [DATA_W-1:0] value;
        value              = $urandom;
        value[GS_W-1:0]    = GS_W'(n);
        write_register(ADDR_GRID_SIZE, value);
    endtask

    task automatic run_sequence(input int n);
        int len;
        int p;
        len = cheap_length(n);
        for (p = 0; p < len && p < 5; p++)
            load_letter(p, pick_letter());
        if (n > 0)
            repeat ($urandom_range(0, 3)) load_cell(region_coord(n), region_coord(n), pick_letter());
        search(len);
        repeat ($urandom_range(1, 4)) read_mark(region_coord(n), region_coord(n));
    endtask

    task automatic run_noise(input int n);
        command_t cmd;
        repeat ($urandom_range(1, 4))
        begin
            cmd = random_command();
            if (cmd.op == OP_SEARCH)
                cmd.len = LEN_W'(cheap_length(n));
            send_command(cmd);
        end
    endtask

    initial
    begin
        result_t got;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            got.kind      = out_ch.result_kind;
            got.counts[0] = out_ch.count_north;
            got.counts[1] = out_ch.count_south;
            got.counts[2] = out_ch.count_east;
            got.counts[3] = out_ch.count_west;
            got.counts[4] = out_ch.count_northeast;
            got.counts[5] = out_ch.count_southeast;
            got.counts[6] = out_ch.count_southwest;
            got.counts[7] = out_ch.count_northwest;
            got.marked    = out_ch.marked;
            board.check_result(got);
            if ($urandom_range(0, 19) == 0)
                rx_steady = !rx_steady;
        end
    end

    initial
    begin
        int i;
        int n;
        int sel;
        int goal;
        board = new();
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= '0;
        in_ch.row            <= '0;
        in_ch.column         <= '0;
        in_ch.character      <= '0;
        in_ch.word_position  <= '0;
        in_ch.word_length    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // marks are all set out of reset
        read_mark(0, 0);
        read_mark(GMAX - 1, GMAX - 1);

        // empty grid: no counts, marks cleared
        wait_idle();
        set_grid_size(0);
        search(3);
        read_mark(5, 5);

        // preload every word position
        tx_steady = 1'b1;
        for (i = 0; i < WMAX; i++)
            load_letter(i, CHAR_W'($urandom));
        tx_steady = 1'b0;

        // oversized grid saturates to the full store; empty word reads no cell
        wait_idle();
        set_grid_size(GS_TOP);
        search(0);
        read_mark(GMAX - 1, GMAX - 1);

        // full grid, empty word; spare register address must not move grid_size
        wait_idle();
        set_grid_size(GMAX);
        write_register(ADDR_SPARE, 32'd5);
        search(0);
        read_mark(GMAX - 1, GMAX - 1);

        // single cell grid
        wait_idle();
        set_grid_size(1);
        load_cell(0, 0, 8'hFF);
        load_letter(0, 8'hFF);
        search(1);
        read_mark(0, 0);
        read_mark(40, 40);
        search(0);
        read_mark(0, 0);
        search(GS_TOP);
        load_cell(50, 50, 8'h00);
        read_mark(50, 50);

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            wait_idle();
            sel = $urandom_range(0, 15);
            if (sel == 0)
                n = 0;
            else if (sel == 1)
                n = $urandom_range(9, 12);
            else
                n = $urandom_range(1, 8);
            set_grid_size(n);
            tx_steady = ($urandom_range(0, 3) == 0);
            letter_a  = CHAR_W'($urandom);
            letter_b  = CHAR_W'($urandom);
            for (i = 0; i < n * n; i++)
                load_cell(i / n, i % n, pick_letter());
            repeat ($urandom_range(3, 6))
            begin
                if ($urandom_range(0, 3) == 0)
                    run_noise(n);
                else
                    run_sequence(n);
            end
        end

        wait_idle();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gws_pkg.sv
hw/rtl/gws_in_if.sv
hw/rtl/gws_out_if.sv
hw/rtl/gws_apb.sv
hw/rtl/gws_mem.sv
hw/rtl/gws_seq.sv
hw/rtl/grid_word_search_eight_dir_core.sv
verif/grid_word_search_eight_dir_core_test.sv
